FILE: hdl/afc_pkg.sv
// -----------------------------------------------------------------------------
// afc_pkg
// Shared constants and types for the box versus frustum culling block.
// -----------------------------------------------------------------------------
package afc_pkg;

   localparam int COORD_WIDTH_DEFAULT = 16;
   localparam int PLANE_COUNT_DEFAULT = 6;
   localparam int PLANE_COUNT_MAX     = 8;

   localparam int CSR_INDEX_W = $clog2(PLANE_COUNT_MAX);
   localparam int CSR_DATA_W  = 64;
   localparam int NORMAL_W    = 16;
   localparam int D_SHIFT     = 14;
   localparam int AXIS_COUNT  = 3;
   localparam int VERDICT_W   = 2;

   localparam logic [VERDICT_W-1:0] VERDICT_OUTSIDE   = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_INTERSECT = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_INSIDE    = 2'd2;

   typedef struct packed {
      logic signed [NORMAL_W-1:0] d;
      logic signed [NORMAL_W-1:0] nz;
      logic signed [NORMAL_W-1:0] ny;
      logic signed [NORMAL_W-1:0] nx;
   } plane_type;

   typedef struct packed {
      logic outside;
      logic full;
   } status_type;

endpackage

FILE: hdl/afc_req_if.sv
// -----------------------------------------------------------------------------
// afc_req_if
// Box request channel: two opposite corners per transaction.
// -----------------------------------------------------------------------------
interface afc_req_if #(
   parameter int COORD_WIDTH = afc_pkg::COORD_WIDTH_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] corner_a_x;
   logic signed [COORD_WIDTH-1:0] corner_b_x;
   logic signed [COORD_WIDTH-1:0] corner_a_y;
   logic signed [COORD_WIDTH-1:0] corner_b_y;
   logic signed [COORD_WIDTH-1:0] corner_a_z;
   logic signed [COORD_WIDTH-1:0] corner_b_z;

   modport source (
      output valid, corner_a_x, corner_b_x, corner_a_y, corner_b_y, corner_a_z, corner_b_z,
      input  ready
   );
   modport sink (
      input  valid, corner_a_x, corner_b_x, corner_a_y, corner_b_y, corner_a_z, corner_b_z,
      output ready
   );
endinterface

FILE: hdl/afc_rsp_if.sv
// -----------------------------------------------------------------------------
// afc_rsp_if
// Verdict response channel: one transaction per box.
// -----------------------------------------------------------------------------
interface afc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [afc_pkg::VERDICT_W-1:0]      verdict;

   modport source (output valid, verdict, input ready);
   modport sink   (input valid, verdict, output ready);
endinterface

FILE: hdl/afc_csr_if.sv
// -----------------------------------------------------------------------------
// afc_csr_if
// Configuration write channel: plane register index and data.
// -----------------------------------------------------------------------------
interface afc_csr_if;
   logic                             valid;
   logic                             ready;
   logic [afc_pkg::CSR_INDEX_W-1:0]  index;
   logic [afc_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/afc_cell.sv
// -----------------------------------------------------------------------------
// afc_cell
// One plane test: three-stage cell that forms the largest and smallest corner
// distance of the box for its plane and folds the result into the status.
// -----------------------------------------------------------------------------
module afc_cell #(
   parameter int COORD_WIDTH = afc_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  afc_pkg::plane_type            plane,
   input  logic                          up_valid,
   output logic                          up_ready,
   input  logic signed [COORD_WIDTH-1:0] lo_in [afc_pkg::AXIS_COUNT],
   input  logic signed [COORD_WIDTH-1:0] hi_in [afc_pkg::AXIS_COUNT],
   input  afc_pkg::status_type           status_in,
   output logic                          dn_valid,
   input  logic                          dn_ready,
   output logic signed [COORD_WIDTH-1:0] lo_out [afc_pkg::AXIS_COUNT],
   output logic signed [COORD_WIDTH-1:0] hi_out [afc_pkg::AXIS_COUNT],
   output afc_pkg::status_type           status_out
);

   localparam int AXES  = afc_pkg::AXIS_COUNT;
   localparam int PW    = afc_pkg::NORMAL_W + COORD_WIDTH;
   localparam int DW    = afc_pkg::NORMAL_W + afc_pkg::D_SHIFT;
   localparam int SW    = ((PW > DW) ? PW : DW) + 2;

   logic signed [afc_pkg::NORMAL_W-1:0] normal [AXES];

   logic                          v1_ff, v2_ff, v3_ff;
   logic                          en1, en2, en3;
   logic signed [COORD_WIDTH-1:0] lo1_ff [AXES], hi1_ff [AXES];
   logic signed [COORD_WIDTH-1:0] lo2_ff [AXES], hi2_ff [AXES];
   logic signed [COORD_WIDTH-1:0] lo3_ff [AXES], hi3_ff [AXES];
   afc_pkg::status_type           st1_ff, st2_ff, st3_ff, st3_in;
   logic signed [PW-1:0]          plo_ff [AXES], phi_ff [AXES];
   logic signed [PW-1:0]          pmax [AXES], pmin [AXES];
   logic signed [SW-1:0]          maxxy_in, minxy_in, maxxy_ff, minxy_ff;
   logic signed [PW-1:0]          maxz_ff, minz_ff;
   logic signed [SW-1:0]          dterm, dmax, dmin;

   assign normal[0] = plane.nx;
   assign normal[1] = plane.ny;
   assign normal[2] = plane.nz;

   assign en3      = !v3_ff || dn_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign up_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= up_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         pmax[a] = (plo_ff[a] > phi_ff[a]) ? plo_ff[a] : phi_ff[a];
         pmin[a] = (plo_ff[a] > phi_ff[a]) ? phi_ff[a] : plo_ff[a];
      end
      maxxy_in = SW'(pmax[0]) + SW'(pmax[1]);
      minxy_in = SW'(pmin[0]) + SW'(pmin[1]);
   end

   always_comb begin
      dterm = SW'(plane.d) <<< afc_pkg::D_SHIFT;
      dmax  = maxxy_ff + SW'(maxz_ff) + dterm;
      dmin  = minxy_ff + SW'(minz_ff) + dterm;
      st3_in.outside = st2_ff.outside || dmax[SW-1] || (dmax == '0);
      st3_in.full    = st2_ff.full && !dmin[SW-1] && (dmin != '0);
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         st1_ff <= status_in;
         for (int a = 0; a < AXES; a++) begin
            lo1_ff[a] <= lo_in[a];
            hi1_ff[a] <= hi_in[a];
            plo_ff[a] <= PW'(normal[a]) * PW'(lo_in[a]);
            phi_ff[a] <= PW'(normal[a]) * PW'(hi_in[a]);
         end
      end
      if (en2) begin
         st2_ff   <= st1_ff;
         lo2_ff   <= lo1_ff;
         hi2_ff   <= hi1_ff;
         maxxy_ff <= maxxy_in;
         minxy_ff <= minxy_in;
         maxz_ff  <= pmax[2];
         minz_ff  <= pmin[2];
      end
      if (en3) begin
         st3_ff <= st3_in;
         lo3_ff <= lo2_ff;
         hi3_ff <= hi2_ff;
      end
   end

   assign dn_valid   = v3_ff;
   assign lo_out     = lo3_ff;
   assign hi_out     = hi3_ff;
   assign status_out = st3_ff;

endmodule

FILE: hdl/aabb_frustum_cull.sv
// -----------------------------------------------------------------------------
// aabb_frustum_cull
// Classifies an axis-aligned box as outside, intersecting or fully inside a
// view frustum held in plane registers, one box per cycle unless the output stalls.
// -----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req_chan  in         valid/ready          corner_a/b_x, _y, _z
//  rsp_chan  out        valid/ready          verdict
//  csr_chan  in         valid/ready (ready   index, data (64-bit plane)
//                       always high)
//
//  One box accepted per cycle unless the output stalls; it passes an ordering
//  stage, then one three-stage cell per plane (multiply, min/max and pair
//  sum, final sum and compare). Reset clears all planes and empties the chain.
//  A stalled response holds its stage; each stage advances when it is empty or
//  its successor advances, so bubbles fill while the output waits.
// -----------------------------------------------------------------------------
module aabb_frustum_cull #(
   parameter int COORD_WIDTH = afc_pkg::COORD_WIDTH_DEFAULT,
   parameter int PLANE_COUNT = afc_pkg::PLANE_COUNT_DEFAULT
) (
   input logic     clock,
   input logic     reset,
   afc_req_if.sink req_chan,
   afc_rsp_if.source rsp_chan,
   afc_csr_if.sink csr_chan
);

   localparam int AXES = afc_pkg::AXIS_COUNT;

   afc_pkg::plane_type            plane_ff [PLANE_COUNT];
   logic                          v0_ff, en0;
   logic signed [COORD_WIDTH-1:0] lo0_ff [AXES], hi0_ff [AXES];
   logic signed [COORD_WIDTH-1:0] ca [AXES], cb [AXES];

   logic                          chain_valid [PLANE_COUNT+1];
   logic                          chain_ready [PLANE_COUNT+1];
   logic signed [COORD_WIDTH-1:0] chain_lo [PLANE_COUNT+1][AXES];
   logic signed [COORD_WIDTH-1:0] chain_hi [PLANE_COUNT+1][AXES];
   afc_pkg::status_type           chain_st [PLANE_COUNT+1];
   afc_pkg::status_type           last_st;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < PLANE_COUNT; p++) begin
            plane_ff[p] <= '0;
         end
      end else if (csr_chan.valid) begin
         for (int p = 0; p < PLANE_COUNT; p++) begin
            if (csr_chan.index == afc_pkg::CSR_INDEX_W'(p)) begin
               plane_ff[p] <= afc_pkg::plane_type'(csr_chan.data);
            end
         end
      end
   end

   assign ca[0] = req_chan.corner_a_x;
   assign cb[0] = req_chan.corner_b_x;
   assign ca[1] = req_chan.corner_a_y;
   assign cb[1] = req_chan.corner_b_y;
   assign ca[2] = req_chan.corner_a_z;
   assign cb[2] = req_chan.corner_b_z;

   assign en0            = !v0_ff || chain_ready[0];
   assign req_chan.ready = en0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en0) begin
         v0_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en0) begin
         for (int a = 0; a < AXES; a++) begin
            lo0_ff[a] <= (ca[a] <= cb[a]) ? ca[a] : cb[a];
            hi0_ff[a] <= (ca[a] <= cb[a]) ? cb[a] : ca[a];
         end
      end
   end

   assign chain_valid[0]      = v0_ff;
   assign chain_lo[0]         = lo0_ff;
   assign chain_hi[0]         = hi0_ff;
   assign chain_st[0].outside = 1'b0;
   assign chain_st[0].full    = 1'b1;

   for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_cell
      afc_cell #(
         .COORD_WIDTH (COORD_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .plane      (plane_ff[p]),
         .up_valid   (chain_valid[p]),
         .up_ready   (chain_ready[p]),
         .lo_in      (chain_lo[p]),
         .hi_in      (chain_hi[p]),
         .status_in  (chain_st[p]),
         .dn_valid   (chain_valid[p+1]),
         .dn_ready   (chain_ready[p+1]),
         .lo_out     (chain_lo[p+1]),
         .hi_out     (chain_hi[p+1]),
         .status_out (chain_st[p+1])
      );
   end

   assign last_st                   = chain_st[PLANE_COUNT];
   assign chain_ready[PLANE_COUNT]  = rsp_chan.ready;
   assign rsp_chan.valid            = chain_valid[PLANE_COUNT];
   assign rsp_chan.verdict          = last_st.outside ? afc_pkg::VERDICT_OUTSIDE   :
                                      last_st.full    ? afc_pkg::VERDICT_INSIDE    :
                                                        afc_pkg::VERDICT_INTERSECT;

endmodule

FILE: sim/aabb_frustum_cull_tb.sv
// -----------------------------------------------------------------------------
// aabb_frustum_cull_tb
// Self-checking bench for the box versus frustum culling block. A driver
// streams boxes from a pending queue and predicts each verdict from a mirror
// of the plane registers; a monitor compares every response in order.
// Directed boxes and planes come first, then random ones under three idle
// patterns and several plane sets.
// -----------------------------------------------------------------------------
module aabb_frustum_cull_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import afc_pkg::*;

   localparam int COORD_W        = COORD_WIDTH_DEFAULT;
   localparam int PLANES         = PLANE_COUNT_DEFAULT;
   localparam int LATENCY        = 3 * PLANES + 1;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int MAX_REPORTS    = 10;
   localparam int UNIT           = 16384;
   localparam int COORD_MAX      = 2 ** (COORD_W - 1) - 1;
   localparam int COORD_MIN      = -(2 ** (COORD_W - 1));

   typedef struct packed {
      logic signed [COORD_W-1:0] ax, bx, ay, by, az, bz;
   } box_type;

   logic clock = 1'b0;
   logic reset;

   afc_req_if #(.COORD_WIDTH(COORD_W)) req_chan ();
   afc_rsp_if rsp_chan ();
   afc_csr_if csr_chan ();

   aabb_frustum_cull #(
      .COORD_WIDTH (COORD_W),
      .PLANE_COUNT (PLANES)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   box_type                box_queue [$];
   logic [VERDICT_W-1:0]   verdict_queue [$];
   plane_type              plane_mirror [PLANES];
   logic [CSR_DATA_W-1:0]  plane_set [PLANE_COUNT_MAX];
   box_type                box_on_bus;
   logic [VERDICT_W-1:0]   want_verdict;
   int                     queued_count = 0;
   int                     accepted_count = 0;
   int                     fault_count = 0;
   int                     quiet_cycles = 0;
   int                     send_idle_pct = 0;
   int                     recv_idle_pct = 0;
   int                     region_c [3];
   int                     region_reach;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [VERDICT_W-1:0] classify_box(box_type b);
      longint xs [2], ys [2], zs [2];
      longint nx, ny, nz, dd, distance;
      int     hits, full_planes;
      xs[0] = (b.ax <= b.bx) ? b.ax : b.bx;
      xs[1] = (b.ax <= b.bx) ? b.bx : b.ax;
      ys[0] = (b.ay <= b.by) ? b.ay : b.by;
      ys[1] = (b.ay <= b.by) ? b.by : b.ay;
      zs[0] = (b.az <= b.bz) ? b.az : b.bz;
      zs[1] = (b.az <= b.bz) ? b.bz : b.az;
      full_planes = 0;
      for (int p = 0; p < PLANES; p++) begin
         nx = plane_mirror[p].nx;
         ny = plane_mirror[p].ny;
         nz = plane_mirror[p].nz;
         dd = plane_mirror[p].d;
         hits = 0;
         for (int c = 0; c < 8; c++) begin
            distance = nx * xs[c & 1] + ny * ys[(c >> 1) & 1] + nz * zs[(c >> 2) & 1]
                     + dd * UNIT;
            if (distance > 0)
               hits++;
         end
         if (hits == 0)
            return VERDICT_OUTSIDE;
         if (hits == 8)
            full_planes++;
      end
      return (full_planes == PLANES) ? VERDICT_INSIDE : VERDICT_INTERSECT;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] make_plane(int nx, int ny, int nz, int d);
      plane_type pl;
      pl.nx = NORMAL_W'(nx);
      pl.ny = NORMAL_W'(ny);
      pl.nz = NORMAL_W'(nz);
      pl.d  = NORMAL_W'(d);
      return pl;
   endfunction

   function automatic logic signed [COORD_W-1:0] saturate_coord(int v);
      if (v > COORD_MAX)
         return COORD_W'(COORD_MAX);
      if (v < COORD_MIN)
         return COORD_W'(COORD_MIN);
      return COORD_W'(v);
   endfunction

   task automatic note_fault(input string msg);
      fault_count++;
      if (fault_count <= MAX_REPORTS)
         $display("%0t: %s", $realtime, msg);
   endtask

   // write plane_set[0..count-1]; indexes past PLANES must be ignored
   task automatic commit_planes(input int count);
      for (int i = 0; i < count; i++) begin
         csr_chan.valid <= 1'b1;
         csr_chan.index <= CSR_INDEX_W'(i);
         csr_chan.data  <= plane_set[i];
         @(posedge clock);
         while (!csr_chan.ready)
            @(posedge clock);
         if (i < PLANES)
            plane_mirror[i] = plane_set[i];
      end
      csr_chan.valid <= 1'b0;
   endtask

   // axis-aligned slab pair per axis: inside when |p - c| < half
   task automatic load_box_frustum(input int cx, input int cy, input int cz,
                                   input int hx, input int hy, input int hz);
      plane_set[0] = make_plane(UNIT, 0, 0, hx - cx);
      plane_set[1] = make_plane(-UNIT, 0, 0, hx + cx);
      plane_set[2] = make_plane(0, UNIT, 0, hy - cy);
      plane_set[3] = make_plane(0, -UNIT, 0, hy + cy);
      plane_set[4] = make_plane(0, 0, UNIT, hz - cz);
      plane_set[5] = make_plane(0, 0, -UNIT, hz + cz);
      commit_planes(PLANES);
   endtask

   task automatic load_uniform_planes(input logic [CSR_DATA_W-1:0] value, input int count);
      for (int i = 0; i < count; i++)
         plane_set[i] = value;
      commit_planes(count);
   endtask

   task automatic push_box(input int ax, input int bx, input int ay, input int by,
                           input int az, input int bz);
      box_type b;
      b.ax = saturate_coord(ax);
      b.bx = saturate_coord(bx);
      b.ay = saturate_coord(ay);
      b.by = saturate_coord(by);
      b.az = saturate_coord(az);
      b.bz = saturate_coord(bz);
      box_queue.push_back(b);
      queued_count++;
   endtask

   task automatic random_span(input int mid, input int reach,
                              output int first, output int second);
      int centre, half, t;
      centre = mid + int'($urandom_range(2 * reach)) - reach;
      case ($urandom_range(3))
         0: half = $urandom_range(200);
         1, 2: half = $urandom_range(reach);
         default: half = $urandom_range(2 * reach);
      endcase
      first  = centre - half;
      second = centre + half;
      if ($urandom_range(1)) begin
         t = first;
         first = second;
         second = t;
      end
   endtask

   task automatic push_random_box();
      box_type b;
      int      s [6];
      if ($urandom_range(99) < 30) begin
         b = {$urandom, $urandom, $urandom};
         box_queue.push_back(b);
         queued_count++;
      end else begin
         for (int a = 0; a < 3; a++)
            random_span(region_c[a], region_reach, s[2*a], s[2*a+1]);
         push_box(s[0], s[1], s[2], s[3], s[4], s[5]);
      end
   endtask

   task automatic load_random_planes(input int kind);
      int h;
      case (kind)
         0: begin
            for (int a = 0; a < 3; a++)
               region_c[a] = int'($urandom_range(8000)) - 4000;
            h = $urandom_range(20000, 1);
            region_reach = h + 2000;
            load_box_frustum(region_c[0], region_c[1], region_c[2],
                             h, $urandom_range(20000, 1), $urandom_range(20000, 1));
         end
         1: begin
            region_c = '{0, 0, 0};
            region_reach = 8000;
            for (int i = 0; i < PLANE_COUNT_MAX; i++)
               plane_set[i] = make_plane(int'($urandom_range(32768)) - UNIT,
                                         int'($urandom_range(32768)) - UNIT,
                                         int'($urandom_range(32768)) - UNIT,
                                         $urandom_range(20000, 2000));
            commit_planes($urandom_range(1) ? PLANE_COUNT_MAX : PLANES);
         end
         default: begin
            region_c = '{0, 0, 0};
            region_reach = COORD_MAX;
            for (int i = 0; i < PLANE_COUNT_MAX; i++)
               plane_set[i] = {$urandom, $urandom};
            commit_planes($urandom_range(1) ? PLANE_COUNT_MAX : PLANES);
         end
      endcase
   endtask

   task automatic wait_drained();
      do
         @(posedge clock);
      while (accepted_count != queued_count || verdict_queue.size() != 0);
   endtask

   // driver: predict on acceptance, then load the next box or idle
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            verdict_queue.push_back(classify_box(box_on_bus));
            accepted_count++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (box_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               box_on_bus = box_queue.pop_front();
               req_chan.corner_a_x <= box_on_bus.ax;
               req_chan.corner_b_x <= box_on_bus.bx;
               req_chan.corner_a_y <= box_on_bus.ay;
               req_chan.corner_b_y <= box_on_bus.by;
               req_chan.corner_a_z <= box_on_bus.az;
               req_chan.corner_b_z <= box_on_bus.bz;
               req_chan.valid <= 1'b1;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each response transaction with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (verdict_queue.size() == 0) begin
               note_fault($sformatf("unexpected verdict %0d", rsp_chan.verdict));
            end else begin
               want_verdict = verdict_queue.pop_front();
               if (rsp_chan.verdict !== want_verdict)
                  note_fault($sformatf("verdict mismatch: expected %0d, actual %0d",
                                       want_verdict, rsp_chan.verdict));
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", quiet_cycles);
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      req_chan.valid      = 1'b0;
      req_chan.corner_a_x = '0;
      req_chan.corner_b_x = '0;
      req_chan.corner_a_y = '0;
      req_chan.corner_b_y = '0;
      req_chan.corner_a_z = '0;
      req_chan.corner_b_z = '0;
      rsp_chan.ready      = 1'b0;
      csr_chan.valid      = 1'b0;
      csr_chan.index      = '0;
      csr_chan.data       = '0;
      for (int i = 0; i < PLANES; i++)
         plane_mirror[i] = '0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // planes still cleared: nothing is inside
      push_box(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
      push_box(0, 0, 0, 0, 0, 0);
      wait_drained();

      // constant positive distance; out-of-range indexes get all ones
      for (int i = 0; i < PLANE_COUNT_MAX; i++)
         plane_set[i] = (i < PLANES) ? make_plane(0, 0, 0, 1) : '1;
      commit_planes(PLANE_COUNT_MAX);
      push_box(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
      push_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
      wait_drained();

      // cube of half size 1000: inside, touching a face, flat on a face, outside
      load_box_frustum(0, 0, 0, 1000, 1000, 1000);
      push_box(-10, 10, -10, 10, -10, 10);
      push_box(10, -10, 500, -500, -999, 999);
      push_box(-1000, 5, 0, 0, 0, 0);
      push_box(-1000, -1000, 0, 0, 0, 0);
      push_box(2000, 3000, 0, 0, 0, 0);
      push_box(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
      push_box(999, -999, 999, -999, 999, -999);
      wait_drained();

      // most negative fields everywhere
      load_uniform_planes(make_plane(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN), PLANES);
      push_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
      push_box(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
      push_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
      wait_drained();

      load_uniform_planes('1, PLANES);
      push_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
      push_box(-1, 1, 0, 0, -16383, 0);
      wait_drained();

      load_uniform_planes(make_plane(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX),
                          PLANE_COUNT_MAX);
      push_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
      push_box(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
      wait_drained();

      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 32 : (mode == 1) ? 71 : 0;
         recv_idle_pct = (mode == 0) ? 71 : (mode == 1) ? 32 : 0;
         for (int kind = 0; kind < 3; kind++) begin
            load_random_planes(kind);
            repeat (78)
               push_random_box();
            wait_drained();
         end
      end

      repeat (LATENCY + 8) @(posedge clock);
      if (fault_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
